// File: src/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define CBCD_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define CBCD_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/cbcd_pkg.sv
package cbcd_pkg;

    // width of the chunk size / payload counter
    localparam int SizeBits = 32;

    // depth of the token queue between front and back
    localparam int QueueDepth = 2;
    localparam int QueuePtrW  = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
    localparam int QueueCntW  = $clog2(QueueDepth + 1);

    typedef logic [7:0] byte_t;
    typedef logic [1:0] status_t;
    typedef logic [SizeBits-1:0] size_t;

    localparam status_t StIncomplete = 2'd0;
    localparam status_t StComplete   = 2'd1;
    localparam status_t StMalformed  = 2'd2;

    localparam byte_t ChCr   = 8'h0d;
    localparam byte_t ChLf   = 8'h0a;
    localparam byte_t ChSemi = 8'h3b;

    // classified byte, as handed from the front to the back
    typedef struct packed {
        logic       restart;
        logic       is_cr;
        logic       is_lf;
        logic       is_semi;
        logic       is_hex;
        logic [3:0] hex_val;
    } tok_t;

    typedef enum logic [12:0] {
        PH_LINE     = 13'b0000000000001,
        PH_LINE_CR  = 13'b0000000000010,
        PH_EXT      = 13'b0000000000100,
        PH_EXT_CR   = 13'b0000000001000,
        PH_BAD      = 13'b0000000010000,
        PH_BAD_CR   = 13'b0000000100000,
        PH_DATA     = 13'b0000001000000,
        PH_DATA_CR  = 13'b0000010000000,
        PH_DATA_LF  = 13'b0000100000000,
        PH_TRAIL    = 13'b0001000000000,
        PH_TRAIL_CR = 13'b0010000000000,
        PH_DONE     = 13'b0100000000000,
        PH_ERROR    = 13'b1000000000000
    } phase_t;

    // hex digit decode
    function automatic logic [4:0] hex_decode(input byte_t c);
        logic [4:0] r;
        r = 5'd16;
        if (c >= 8'h30 && c <= 8'h39) r = {1'b0, c[3:0]};
        else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
            r = {1'b0, c[3:0] + 4'd9};
        return r;
    endfunction

endpackage

// File: src/cbcd_in_if.sv
interface cbcd_in_if;
    logic            valid;
    logic            ready;
    cbcd_pkg::byte_t body_byte;
    logic            first_byte;

    modport source (output valid, output body_byte, output first_byte, input ready);
    modport sink   (input valid, input body_byte, input first_byte, output ready);
endinterface

// File: src/cbcd_out_if.sv
interface cbcd_out_if;
    logic              valid;
    logic              ready;
    cbcd_pkg::status_t status;

    modport source (output valid, output status, input ready);
    modport sink   (input valid, input status, output ready);
endinterface

// File: src/cbcd_front.sv
module cbcd_front (
    cbcd_in_if.sink      body,
    output logic         push,
    output cbcd_pkg::tok_t push_tok,
    input  logic         push_ready
);
    import cbcd_pkg::*;

    logic [4:0] hex;

    assign hex        = hex_decode(body.body_byte);
    assign body.ready = push_ready;
    assign push       = body.valid;

    always_comb
    begin
        push_tok.restart = body.first_byte;
        push_tok.is_cr   = (body.body_byte == ChCr);
        push_tok.is_lf   = (body.body_byte == ChLf);
        push_tok.is_semi = (body.body_byte == ChSemi);
        push_tok.is_hex  = ~hex[4];
        push_tok.hex_val = hex[3:0];
    end

endmodule

// File: src/cbcd_queue.sv
module cbcd_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  cbcd_pkg::tok_t push_tok,
    output logic           push_ready,
    output logic           pop_valid,
    output cbcd_pkg::tok_t pop_tok,
    input  logic           pop
);
    import cbcd_pkg::*;

    tok_t                 slot_reg [QueueDepth];
    logic [QueuePtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QueuePtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QueueCntW-1:0] count_reg, count_next;
    logic                 do_push, do_pop;

    assign push_ready = (count_reg != QueueCntW'(QueueDepth));
    assign pop_valid  = (count_reg != '0);
    assign pop_tok    = slot_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QueuePtrW'(QueueDepth - 1)) ? '0
                                                                      : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QueuePtrW'(QueueDepth - 1)) ? '0
                                                                      : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_tok;
    end

endmodule

// File: src/cbcd_back.sv
module cbcd_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           pop_valid,
    input  cbcd_pkg::tok_t pop_tok,
    output logic           pop,
    cbcd_out_if.source     report
);
    import cbcd_pkg::*;

    phase_t  phase_reg, phase_next;
    size_t   cnt_reg, cnt_next;
    logic    seen_reg, seen_next;
    logic    out_valid_reg;
    status_t status_reg, status_next;

    phase_t  ph;
    size_t   cnt;
    logic    seen;
    phase_t  end_line;

    // take a token whenever the output register is free or being drained
    assign pop           = pop_valid && (!out_valid_reg || report.ready);
    assign report.valid  = out_valid_reg;
    assign report.status = status_reg;

    always_comb
    begin
        ph   = pop_tok.restart ? PH_LINE : phase_reg;
        cnt  = pop_tok.restart ? '0 : cnt_reg;
        seen = pop_tok.restart ? 1'b0 : seen_reg;

        // outcome of a size line closed by cr lf
        if (!seen)
            end_line = PH_ERROR;
        else if (cnt == '0)
            end_line = PH_TRAIL;
        else
            end_line = PH_DATA;

        phase_next = ph;
        cnt_next   = cnt;
        seen_next  = seen;

        case (ph)
            PH_LINE:
            begin
                if (pop_tok.is_cr)
                    phase_next = PH_LINE_CR;
                else if (pop_tok.is_semi)
                    phase_next = seen ? PH_EXT : PH_BAD;
                else if (!pop_tok.is_hex || (|cnt[SizeBits-1 -: 4]))
                    phase_next = PH_BAD;
                else
                begin
                    cnt_next  = {cnt[SizeBits-5:0], pop_tok.hex_val};
                    seen_next = 1'b1;
                end
            end
            PH_LINE_CR:
            begin
                if (pop_tok.is_lf)
                    phase_next = end_line;
                else
                    phase_next = pop_tok.is_cr ? PH_BAD_CR : PH_BAD;
            end
            PH_EXT:
            begin
                if (pop_tok.is_cr)
                    phase_next = PH_EXT_CR;
            end
            PH_EXT_CR:
            begin
                if (pop_tok.is_lf)
                    phase_next = end_line;
                else if (!pop_tok.is_cr)
                    phase_next = PH_EXT;
            end
            PH_BAD:
            begin
                if (pop_tok.is_cr)
                    phase_next = PH_BAD_CR;
            end
            PH_BAD_CR:
            begin
                if (pop_tok.is_lf)
                    phase_next = PH_ERROR;
                else if (!pop_tok.is_cr)
                    phase_next = PH_BAD;
            end
            PH_DATA:
            begin
                cnt_next = cnt - size_t'(1);
                if (cnt == size_t'(1))
                    phase_next = PH_DATA_CR;
            end
            PH_DATA_CR:
            begin
                phase_next = pop_tok.is_cr ? PH_DATA_LF : PH_ERROR;
            end
            PH_DATA_LF:
            begin
                if (pop_tok.is_lf)
                begin
                    phase_next = PH_LINE;
                    cnt_next   = '0;
                    seen_next  = 1'b0;
                end
                else
                    phase_next = PH_ERROR;
            end
            PH_TRAIL:
            begin
                if (pop_tok.is_cr)
                    phase_next = PH_TRAIL_CR;
            end
            PH_TRAIL_CR:
            begin
                if (pop_tok.is_lf)
                    phase_next = PH_DONE;
                else if (!pop_tok.is_cr)
                    phase_next = PH_TRAIL;
            end
            PH_DONE:
            begin
                phase_next = PH_DONE;
            end
            default:
            begin
                phase_next = PH_ERROR;
            end
        endcase

        if (phase_next == PH_DONE)
            status_next = StComplete;
        else if (phase_next == PH_ERROR)
            status_next = StMalformed;
        else
            status_next = StIncomplete;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_LINE;
            cnt_reg       <= '0;
            seen_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                phase_reg <= phase_next;
                cnt_reg   <= cnt_next;
                seen_reg  <= seen_next;
            end
            if (pop)
                out_valid_reg <= 1'b1;
            else if (report.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            status_reg <= status_next;
    end

endmodule

// File: src/chunked_body_completion_detector.sv
// Checks HTTP/1.1 chunked body framing, one body byte per item, and returns one
// status item for every byte: incomplete, complete (a zero-size chunk line and a
// following CR LF were seen) or malformed; complete and malformed hold until an
// item with first_byte set restarts the parse. Sustained rate is one byte per
// clock cycle while report.ready stays high. A taken byte's status reaches the
// output register in registered steps: the front classifies the byte into a
// two-entry token queue, and the back end's parse step, with its 32-bit
// size/payload counter, updates the framing state and loads the status register.
// Either side may stall; the queue and output register absorb up to three items in flight.
module chunked_body_completion_detector (
    input  logic       clk,
    input  logic       rst_n,
    cbcd_in_if.sink    body,
    cbcd_out_if.source report
);
    import cbcd_pkg::*;

    logic push, push_ready, pop_valid, pop;
    tok_t push_tok, pop_tok;

    cbcd_front u_front (
        .body       (body),
        .push       (push),
        .push_tok   (push_tok),
        .push_ready (push_ready)
    );

    cbcd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_tok   (push_tok),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_tok    (pop_tok),
        .pop        (pop)
    );

    cbcd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_tok   (pop_tok),
        .pop       (pop),
        .report    (report)
    );

endmodule

// File: src/cbcd_checker.sv
`include "assert_macros.svh"

module cbcd_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input cbcd_pkg::status_t status
);
    import cbcd_pkg::*;

    // items taken but not yet delivered
    logic [2:0] pending_reg, pending_next;
    logic       in_fire, out_fire;
    logic       stalled;

    assign in_fire  = in_valid && in_ready;
    assign out_fire = out_valid && out_ready;
    assign stalled  = out_valid && !out_ready;

    always_comb
    begin
        pending_next = pending_reg;
        if (in_fire && !out_fire)
            pending_next = pending_reg + 1'b1;
        else if (out_fire && !in_fire)
            pending_next = pending_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pending_reg <= '0;
        else
            pending_reg <= pending_next;
    end

    `CBCD_ASSERT_NXT(a_stall_hold, stalled, out_valid && $stable(status), "stalled status changed")
    `CBCD_ASSERT_IMP(a_status_code, out_valid, status != 2'd3, "status code out of range")
    `CBCD_ASSERT_IMP(a_no_phantom, out_valid, pending_reg != 3'd0, "status with no byte pending")
    `CBCD_ASSERT_IMP(a_bounded, 1'b1, pending_reg <= 3'(QueueDepth + 1), "too many in flight")

endmodule

bind chunked_body_completion_detector cbcd_checker u_cbcd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (body.valid),
    .in_ready  (body.ready),
    .out_valid (report.valid),
    .out_ready (report.ready),
    .status    (report.status)
);
